// ===== rtl/ate_pkg.sv =====
package ate_pkg;

  localparam int Depth = 64;
  localparam int IdxW  = 6;
  localparam int CntW  = 7;
  localparam int ValW  = 32;

  typedef enum logic [3:0] {
    CMD_APPEND    = 4'd0,
    CMD_FIND      = 4'd1,
    CMD_DELETE    = 4'd2,
    CMD_SWAP      = 4'd3,
    CMD_SORT      = 4'd4,
    CMD_READ_FWD  = 4'd5,
    CMD_READ_REV  = 4'd6,
    CMD_READ_EVEN = 4'd7,
    CMD_READ_ODD  = 4'd8
  } cmd_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // operation applied by every cell at once
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_DELETE,
    OP_SWAP,
    OP_SORT_EVEN,
    OP_SORT_ODD,
    OP_ROTATE,
    OP_ROTATE_BACK
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IdxW-1:0]   pos;
    logic [CntW-1:0]   count;
    logic [ValW-1:0]   value;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT,
    S_READ,
    S_RESULT,
    S_WAIT
  } state_t;

endpackage

// ===== rtl/array_table_engine_top.sv =====
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | command, operand_value
// out     | out_valid | out_stall | status, entry_index, entry_value, fill_count, last
// A row of 64 cells holds the entries; a scan rotates the row one cell a cycle when
// no result is stalled. Append, find, delete and reads scan the row, sort runs its steps;
// then the result and wait states free the input. Swap and unknown skip to result and wait.
// Reads give one result per hit, held back one hit so the last mark is known.
// rst clears the fill count and control; entries are not cleared.
// A stalled result freezes the row until it is taken.
module array_table_engine_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               command,
  input  logic signed [31:0]       operand_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               status,
  output logic [5:0]               entry_index,
  output logic signed [31:0]       entry_value,
  output logic [6:0]               fill_count,
  output logic                     last
);

  localparam int IW = ate_pkg::IdxW;
  localparam int CW = ate_pkg::CntW;

  ate_pkg::state_t state, state_next;
  ate_pkg::cell_ctl_t ctl;
  logic [ate_pkg::ValW-1:0] head;
  logic [ate_pkg::ValW-1:0] tail;
  logic [ate_pkg::ValW-1:0] scan_value;

  logic [3:0]   cmd;
  logic [31:0]  opv;
  logic [CW-1:0] count;
  logic [CW-1:0] step;        // rotation / sort step counter
  logic          found;
  logic [IW-1:0] fpos;
  logic [31:0]   fval;
  logic [IW-1:0] pend_idx;
  logic [31:0]   pend_val;
  logic          pend;
  logic          rev;

  logic [IW-1:0] cur_idx;
  logic          cur_live;
  logic          cur_hit;
  logic          out_free;

  logic          res_load;
  logic [2:0]    res_status;
  logic [IW-1:0] res_idx;
  logic [31:0]   res_val;
  logic [CW-1:0] res_fill;
  logic          res_last;

  // forward scans watch the head; a reverse read rotates backwards and watches the tail
  assign rev        = (cmd == ate_pkg::CMD_READ_REV);
  assign scan_value = rev ? tail : head;
  assign cur_idx    = rev ? ~step[IW-1:0] : step[IW-1:0];
  assign cur_live   = {1'b0, cur_idx} < count;
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    cur_hit = 1'b0;
    unique case (cmd)
      ate_pkg::CMD_READ_FWD, ate_pkg::CMD_READ_REV: cur_hit = cur_live;
      ate_pkg::CMD_READ_EVEN: cur_hit = cur_live && !scan_value[0];
      ate_pkg::CMD_READ_ODD:  cur_hit = cur_live && scan_value[0];
      default: cur_hit = 1'b0;
    endcase
  end

  ate_chain u_chain (.clk(clk), .ctl(ctl), .head_value(head), .tail_value(tail));

  assign in_stall = (state != ate_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    ctl.op    = ate_pkg::OP_HOLD;
    ctl.pos   = fpos;
    ctl.count = count;
    ctl.value = opv;
    unique case (state)
      ate_pkg::S_IDLE: begin
        if (in_valid) begin
          if (command == ate_pkg::CMD_SWAP) begin
            ctl.op = ate_pkg::OP_SWAP;
            state_next = ate_pkg::S_RESULT;
          end else if (command == ate_pkg::CMD_SORT) state_next = ate_pkg::S_SORT;
          else if (command <= ate_pkg::CMD_READ_ODD) state_next = ate_pkg::S_READ;
          else state_next = ate_pkg::S_RESULT;
        end
      end
      ate_pkg::S_SORT: begin
        ctl.op = step[0] ? ate_pkg::OP_SORT_ODD : ate_pkg::OP_SORT_EVEN;
        if (step == CW'(ate_pkg::Depth - 1)) state_next = ate_pkg::S_RESULT;
      end
      ate_pkg::S_READ: begin
        if (out_free) begin
          if (rev) ctl.op = ate_pkg::OP_ROTATE_BACK;
          else     ctl.op = ate_pkg::OP_ROTATE;
          if (step == CW'(ate_pkg::Depth - 1)) state_next = ate_pkg::S_RESULT;
        end
      end
      ate_pkg::S_RESULT: begin
        if (out_free) begin
          if (cmd == ate_pkg::CMD_APPEND && count < CW'(ate_pkg::Depth) && !found)
            ctl.op = ate_pkg::OP_APPEND;
          else if (cmd == ate_pkg::CMD_DELETE && found)
            ctl.op = ate_pkg::OP_DELETE;
          state_next = ate_pkg::S_WAIT;
        end
      end
      ate_pkg::S_WAIT: begin
        if (out_free) state_next = ate_pkg::S_IDLE;
      end
      default: state_next = ate_pkg::S_IDLE;
    endcase
  end

  // next result and when it is loaded
  always_comb begin
    res_load   = 1'b0;
    res_status = ate_pkg::ST_OK;
    res_idx    = '0;
    res_val    = '0;
    res_fill   = count;
    res_last   = 1'b1;
    unique case (state)
      ate_pkg::S_READ: begin
        if (out_free && cur_hit && pend) begin
          res_load = 1'b1;
          res_idx  = pend_idx;
          res_val  = pend_val;
          res_last = 1'b0;
        end
      end
      ate_pkg::S_RESULT: begin
        res_load = out_free;
        unique case (cmd)
          ate_pkg::CMD_APPEND: begin
            if (count >= CW'(ate_pkg::Depth)) res_status = ate_pkg::ST_FULL;
            else if (found) begin
              res_status = ate_pkg::ST_DUP;
              res_idx    = fpos;
              res_val    = fval;
            end else begin
              res_idx  = count[IW-1:0];
              res_val  = opv;
              res_fill = count + CW'(1);
            end
          end
          ate_pkg::CMD_FIND, ate_pkg::CMD_DELETE: begin
            if (found) begin
              res_idx = fpos;
              res_val = fval;
              if (cmd == ate_pkg::CMD_DELETE) res_fill = count - CW'(1);
            end else res_status = ate_pkg::ST_NOTFOUND;
          end
          ate_pkg::CMD_READ_FWD, ate_pkg::CMD_READ_REV,
          ate_pkg::CMD_READ_EVEN, ate_pkg::CMD_READ_ODD: begin
            if (pend) begin
              res_idx = pend_idx;
              res_val = pend_val;
            end else res_status = ate_pkg::ST_EMPTY;
          end
          default: res_status = ate_pkg::ST_OK;
        endcase
      end
      default: res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ate_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      step      <= '0;
      found     <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid   <= 1'b1;
        status      <= res_status;
        entry_index <= res_idx;
        entry_value <= res_val;
        fill_count  <= res_fill;
        last        <= res_last;
      end else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ate_pkg::S_RESULT && res_load) count <= res_fill;
      unique case (state)
        ate_pkg::S_IDLE: begin
          step    <= '0;
          found   <= 1'b0;
          pend    <= 1'b0;
          fpos    <= '0;
          fval    <= '0;
          if (in_valid) begin
            cmd <= command;
            opv <= operand_value;
          end
        end
        ate_pkg::S_SORT: step <= step + CW'(1);
        ate_pkg::S_READ: begin
          if (out_free) begin
            step <= step + CW'(1);
            if (cmd == ate_pkg::CMD_APPEND || cmd == ate_pkg::CMD_FIND ||
                cmd == ate_pkg::CMD_DELETE) begin
              if (!found && cur_live && scan_value == opv) begin
                found <= 1'b1;
                fpos  <= cur_idx;
                fval  <= scan_value;
              end
            end else if (cur_hit) begin
              pend     <= 1'b1;
              pend_idx <= cur_idx;
              pend_val <= scan_value;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(entry_value) && $stable(last))
    else $error("result changed while stalled");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ate_pkg::Depth))
    else $error("fill count overflow");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    state != ate_pkg::S_IDLE |-> $stable(count) || state == ate_pkg::S_WAIT)
    else $error("count changed mid command");

endmodule

// ===== rtl/ate_cell.sv =====
module ate_cell (
  input  logic                         clk,
  input  ate_pkg::cell_ctl_t           ctl,
  input  logic [ate_pkg::IdxW-1:0]     my_index,
  input  logic [ate_pkg::ValW-1:0]     left_value,
  input  logic [ate_pkg::ValW-1:0]     right_value,
  output logic [ate_pkg::ValW-1:0]     value
);

  logic [ate_pkg::ValW-1:0] value_next;
  logic [ate_pkg::CntW-1:0] idx_ext;
  logic                     is_even;
  logic                     pair_lo, pair_hi;
  logic                     in_range_hi;

  assign idx_ext     = {1'b0, my_index};
  assign is_even     = ~my_index[0];
  assign in_range_hi = (idx_ext + 7'd1) < ctl.count;

  always_comb begin
    value_next = value;
    pair_lo = 1'b0;
    pair_hi = 1'b0;
    unique case (ctl.op)
      ate_pkg::OP_HOLD: value_next = value;
      ate_pkg::OP_APPEND: begin
        if (idx_ext == ctl.count) value_next = ctl.value;
      end
      ate_pkg::OP_DELETE: begin
        if (my_index >= ctl.pos && in_range_hi) value_next = right_value;
      end
      ate_pkg::OP_SWAP: begin
        if (is_even && in_range_hi) value_next = right_value;
        else if (!is_even && idx_ext < ctl.count) value_next = left_value;
      end
      ate_pkg::OP_SORT_EVEN, ate_pkg::OP_SORT_ODD: begin
        // odd-even transposition: cell compares with its partner
        pair_lo = (is_even == (ctl.op == ate_pkg::OP_SORT_EVEN)) && in_range_hi;
        pair_hi = (is_even != (ctl.op == ate_pkg::OP_SORT_EVEN)) && my_index != '0
                  && idx_ext < ctl.count;
        if (pair_lo && $signed(value) > $signed(right_value)) value_next = right_value;
        else if (pair_hi && $signed(left_value) > $signed(value)) value_next = left_value;
      end
      ate_pkg::OP_ROTATE: value_next = right_value;
      ate_pkg::OP_ROTATE_BACK: value_next = left_value;
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== rtl/ate_chain.sv =====
module ate_chain (
  input  logic                     clk,
  input  ate_pkg::cell_ctl_t       ctl,
  output logic [ate_pkg::ValW-1:0] head_value,
  output logic [ate_pkg::ValW-1:0] tail_value
);

  logic [ate_pkg::ValW-1:0] vals [ate_pkg::Depth];

  for (genvar g = 0; g < ate_pkg::Depth; g++) begin : g_cell
    ate_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .my_index    (ate_pkg::IdxW'(g)),
      .left_value  (vals[(g + ate_pkg::Depth - 1) % ate_pkg::Depth]),
      .right_value (vals[(g + 1) % ate_pkg::Depth]),
      .value       (vals[g])
    );
  end

  assign head_value = vals[0];
  assign tail_value = vals[ate_pkg::Depth-1];

endmodule

// ===== tb/array_table_engine_top_tb.sv =====
`timescale 1ns / 100ps

module array_table_engine_top_tb;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] entry_value;
    logic [6:0]  fill_count;
    logic        last;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  command = '0;
  logic signed [31:0] operand_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  entry_index;
  logic signed [31:0] entry_value;
  logic [6:0]  fill_count;
  logic        last;

  // model of the store as the block should see it
  logic [31:0]     model_entries [ate_pkg::Depth];
  int unsigned     model_count;
  table_result_t   pending_results [$];
  int              fail_count;
  int              result_count;
  int              requests_sent;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_off;

  array_table_engine_top dut (
    .clk, .rst, .in_valid, .in_stall, .command, .operand_value,
    .out_valid, .out_stall, .status, .entry_index, .entry_value, .fill_count, .last
  );

  always #2 clk = ~clk;

  function automatic int find_first(logic [31:0] v);
    for (int i = 0; i < model_count; i++) begin
      if (model_entries[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic table_result_t make_result(logic [2:0] st, int idx, logic [31:0] v,
                                                logic lst);
    table_result_t r;
    r.status = st;
    r.entry_index = idx[5:0];
    r.entry_value = v;
    r.fill_count = model_count[6:0];
    r.last = lst;
    return r;
  endfunction

  task automatic predict_table(logic [3:0] cmd, logic [31:0] v);
    int pos;
    int hits;
    int idx;
    logic [31:0] t;
    pos = find_first(v);
    hits = 0;
    case (cmd)
      ate_pkg::CMD_APPEND: begin
        if (model_count >= ate_pkg::Depth) begin
          pending_results.push_back(make_result(ate_pkg::ST_FULL, 0, 0, 1'b1));
        end else if (pos >= 0) begin
          pending_results.push_back(make_result(ate_pkg::ST_DUP, pos, model_entries[pos],
                                                1'b1));
        end else begin
          model_entries[model_count] = v;
          model_count++;
          pending_results.push_back(make_result(ate_pkg::ST_OK, model_count - 1, v, 1'b1));
        end
      end
      ate_pkg::CMD_FIND: begin
        if (pos >= 0)
          pending_results.push_back(make_result(ate_pkg::ST_OK, pos, model_entries[pos],
                                                1'b1));
        else pending_results.push_back(make_result(ate_pkg::ST_NOTFOUND, 0, 0, 1'b1));
      end
      ate_pkg::CMD_DELETE: begin
        if (pos >= 0) begin
          t = model_entries[pos];
          for (int i = pos; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
          model_count--;
          pending_results.push_back(make_result(ate_pkg::ST_OK, pos, t, 1'b1));
        end else begin
          pending_results.push_back(make_result(ate_pkg::ST_NOTFOUND, 0, 0, 1'b1));
        end
      end
      ate_pkg::CMD_SWAP: begin
        for (int i = 0; i + 1 < model_count; i += 2) begin
          t = model_entries[i];
          model_entries[i] = model_entries[i + 1];
          model_entries[i + 1] = t;
        end
        pending_results.push_back(make_result(ate_pkg::ST_OK, 0, 0, 1'b1));
      end
      ate_pkg::CMD_SORT: begin
        for (int i = 0; i < model_count; i++) begin
          for (int j = i + 1; j < model_count; j++) begin
            if ($signed(model_entries[i]) > $signed(model_entries[j])) begin
              t = model_entries[i];
              model_entries[i] = model_entries[j];
              model_entries[j] = t;
            end
          end
        end
        pending_results.push_back(make_result(ate_pkg::ST_OK, 0, 0, 1'b1));
      end
      ate_pkg::CMD_READ_FWD, ate_pkg::CMD_READ_REV,
      ate_pkg::CMD_READ_EVEN, ate_pkg::CMD_READ_ODD: begin
        for (int i = 0; i < model_count; i++) begin
          idx = (cmd == ate_pkg::CMD_READ_REV) ? model_count - 1 - i : i;
          t = model_entries[idx];
          if (cmd == ate_pkg::CMD_READ_EVEN && t[0]) continue;
          if (cmd == ate_pkg::CMD_READ_ODD && !t[0]) continue;
          pending_results.push_back(make_result(ate_pkg::ST_OK, idx, t, 1'b0));
          hits++;
        end
        if (hits == 0) pending_results.push_back(make_result(ate_pkg::ST_EMPTY, 0, 0, 1'b1));
        else pending_results[$].last = 1'b1;
      end
      default: pending_results.push_back(make_result(ate_pkg::ST_OK, 0, 0, 1'b1));
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // one request, started at a falling edge; prediction is made when it is accepted.
  // Valid stays up until the next request idles or stop_sending drops it.
  task automatic send_request(logic [3:0] cmd, logic [31:0] v);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    command <= cmd;
    operand_value <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table(cmd, v);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {status, entry_index}, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (entry_index !== want.entry_index)
          report_mismatch("entry_index", entry_index, want.entry_index);
        if (entry_value !== want.entry_value)
          report_mismatch("entry_value", entry_value, want.entry_value);
        if (fill_count !== want.fill_count)
          report_mismatch("fill_count", fill_count, want.fill_count);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 4 && model_count > 0) return model_entries[$urandom_range(model_count - 1)];
    if (r < 7) return $urandom_range(40) - 20;
    return $urandom;
  endfunction

  task automatic test_directed();
    send_request(ate_pkg::CMD_READ_FWD, 0);
    send_request(ate_pkg::CMD_FIND, 5);
    send_request(ate_pkg::CMD_DELETE, 5);
    send_request(ate_pkg::CMD_SWAP, 0);
    send_request(ate_pkg::CMD_SORT, 0);
    send_request(ate_pkg::CMD_APPEND, 32'h7fff_ffff);
    send_request(ate_pkg::CMD_APPEND, 32'h8000_0000);
    send_request(ate_pkg::CMD_APPEND, 32'hffff_ffff);
    send_request(ate_pkg::CMD_APPEND, 0);
    send_request(ate_pkg::CMD_APPEND, 32'h8000_0000);
    send_request(ate_pkg::CMD_APPEND, 7);
    send_request(ate_pkg::CMD_READ_EVEN, 0);
    send_request(ate_pkg::CMD_READ_ODD, 0);
    send_request(ate_pkg::CMD_READ_REV, 0);
    send_request(ate_pkg::CMD_SWAP, 0);
    send_request(ate_pkg::CMD_READ_FWD, 0);
    send_request(ate_pkg::CMD_SORT, 0);
    send_request(ate_pkg::CMD_READ_FWD, 0);
    send_request(ate_pkg::CMD_FIND, 0);
    send_request(ate_pkg::CMD_DELETE, 32'h8000_0000);
    send_request(ate_pkg::CMD_DELETE, 1234);
    send_request(4'd9, 0);
    send_request(4'd15, 32'h5555_aaaa);
  endtask

  // fill to the top, prove a full store rejects appends, then sort, read and delete down to four
  task automatic test_full_store();
    while (model_count < ate_pkg::Depth) send_request(ate_pkg::CMD_APPEND, $urandom);
    send_request(ate_pkg::CMD_APPEND, 32'h1357_9bdf);
    send_request(ate_pkg::CMD_SORT, 0);
    send_request(ate_pkg::CMD_READ_REV, 0);
    send_request(ate_pkg::CMD_READ_ODD, 0);
    while (model_count > 4)
      send_request(ate_pkg::CMD_DELETE, model_entries[$urandom_range(model_count - 1)]);
  endtask

  task automatic test_random(int n);
    int r;
    logic [3:0] cmd;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) cmd = ate_pkg::CMD_APPEND;
      else if (r < 50) cmd = ate_pkg::CMD_FIND;
      else if (r < 65) cmd = ate_pkg::CMD_DELETE;
      else if (r < 70) cmd = ate_pkg::CMD_SWAP;
      else if (r < 75) cmd = ate_pkg::CMD_SORT;
      else if (r < 97) cmd = 4'(ate_pkg::CMD_READ_FWD + $urandom_range(3));
      else cmd = 4'($urandom_range(15, 9));
      send_request(cmd, pick_value());
    end
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(12);
    join
  endtask

  task automatic drain();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    requests_sent = 0;
    model_count = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 21;
    recv_idle_pct = 67;
    test_full_store();
    test_random(80);
    send_idle_pct = 67;
    recv_idle_pct = 21;
    test_backpressure();
    test_random(80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(40);
    drain();
    $display("Covered %0d requests and %0d results: all commands, full store, extremes,",
             requests_sent, result_count);
    $display("empty reads, unknown commands and a long output hold-off.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

endmodule
